[hw/rtl/lmsd_pkg.sv]
// Shared constants and types for the lattice minimum-image distance block.
package lmsd_pkg;

    localparam int FIELD_W    = 16;
    localparam int OUT_W      = 36;
    localparam int SIDE_REG_W = 9;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 9;

    localparam logic [SIDE_REG_W-1:0] SIDE_RESET = 9'd64;

    localparam int NUM_AXES   = 3;
    localparam int NUM_COORDS = 6;

    // distinct image offsets per Cartesian axis: x sees -3..3 sides, y -2..2, z -1..1
    localparam int NX   = 7;
    localparam int NY   = 5;
    localparam int NZ   = 3;
    localparam int NIMG = 27;

    // remainder bits resolved per pipeline stage
    localparam int DIV_STEP = 4;

    typedef enum logic {
        BOUND_PERIODIC = 1'b0,
        BOUND_STATIC   = 1'b1
    } bound_mode_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BOUNDARY_MODE = 1'b0,
        CFG_BOX_SIDE      = 1'b1
    } cfg_index_t;

    typedef struct packed {
        bound_mode_t           mode;
        logic [SIDE_REG_W-1:0] box_side;
    } cfg_t;

endpackage

[hw/rtl/lmsd_pair_if.sv]
// Stream interface carrying one pair of lattice points.
interface lmsd_pair_if
    import lmsd_pkg::*;
;
    logic               valid;
    logic               ready;
    logic [FIELD_W-1:0] point_a_t;
    logic [FIELD_W-1:0] point_a_u;
    logic [FIELD_W-1:0] point_a_v;
    logic [FIELD_W-1:0] point_b_t;
    logic [FIELD_W-1:0] point_b_u;
    logic [FIELD_W-1:0] point_b_v;

    modport source (
        output valid, point_a_t, point_a_u, point_a_v, point_b_t, point_b_u, point_b_v,
        input  ready
    );

    modport sink (
        input  valid, point_a_t, point_a_u, point_a_v, point_b_t, point_b_u, point_b_v,
        output ready
    );
endinterface

[hw/rtl/lmsd_dist_if.sv]
// Stream interface carrying one squared distance result.
interface lmsd_dist_if
    import lmsd_pkg::*;
;
    logic             valid;
    logic             ready;
    logic [OUT_W-1:0] squared_distance;

    modport source (
        output valid, squared_distance,
        input  ready
    );

    modport sink (
        input  valid, squared_distance,
        output ready
    );
endinterface

[hw/rtl/lattice_min_image_sq_distance.sv]
// Top level of the lattice minimum-image squared distance block.
// Takes one point pair per cycle while the output is not stalled and returns its
// squared Cartesian distance (x = t+u-v, y = t-u, z = v); a stall at the output
// holds only the full stages in front of it, so bubbles still fill while a result
// waits. The remainder pipeline resolves four bits of each coordinate's remainder
// by the box side per stage and is followed by the candidate, square, norm and
// three-level minimum stages. Write boundary_mode and box_side only while no
// pair is in flight; a side of zero acts as one and sides above MAX_SIDE saturate.
module lattice_min_image_sq_distance
    import lmsd_pkg::*;
#(
    parameter int MAX_SIDE   = 256,
    parameter int COORD_BITS = 16
)(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    lmsd_pair_if.sink             pair,
    lmsd_dist_if.source           result
);

    localparam int SIDE_W = $clog2(MAX_SIDE + 1);
    localparam int DIFF_W = ((COORD_BITS > SIDE_W) ? COORD_BITS : SIDE_W) + 4;
    localparam int SUM_W  = 2 * DIFF_W;

    bound_mode_t           mode_reg;
    logic [SIDE_REG_W-1:0] side_reg;
    cfg_t                  cfg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= BOUND_PERIODIC;
            side_reg <= SIDE_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_BOUNDARY_MODE: mode_reg <= bound_mode_t'(cfg_data[0]);
                CFG_BOX_SIDE:      side_reg <= cfg_data[SIDE_REG_W-1:0];
            endcase
        end
    end

    assign cfg.mode     = mode_reg;
    assign cfg.box_side = side_reg;

    logic [FIELD_W-1:0] coord [NUM_COORDS];

    assign coord[0] = pair.point_a_t;
    assign coord[1] = pair.point_a_u;
    assign coord[2] = pair.point_a_v;
    assign coord[3] = pair.point_b_t;
    assign coord[4] = pair.point_b_u;
    assign coord[5] = pair.point_b_v;

    logic                     wr_valid, wr_ready;
    logic signed [DIFF_W-1:0] wr_diff [NUM_AXES];
    logic [SIDE_W-1:0]        wr_side;
    logic                     im_valid, im_ready;
    logic [SUM_W-1:0]         im_norm [NIMG];

    lmsd_wrap #(
        .MAX_SIDE   (MAX_SIDE),
        .COORD_BITS (COORD_BITS),
        .SIDE_W     (SIDE_W),
        .DIFF_W     (DIFF_W)
    ) u_wrap (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (pair.valid),
        .in_ready  (pair.ready),
        .coord     (coord),
        .out_valid (wr_valid),
        .out_ready (wr_ready),
        .diff      (wr_diff),
        .side      (wr_side)
    );

    lmsd_image_sq #(
        .SIDE_W (SIDE_W),
        .DIFF_W (DIFF_W)
    ) u_image (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (wr_valid),
        .in_ready  (wr_ready),
        .diff      (wr_diff),
        .side      (wr_side),
        .out_valid (im_valid),
        .out_ready (im_ready),
        .norm      (im_norm)
    );

    lmsd_min_tree #(
        .SUM_W (SUM_W)
    ) u_min (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (im_valid),
        .in_ready         (im_ready),
        .norm             (im_norm),
        .out_valid        (result.valid),
        .out_ready        (result.ready),
        .squared_distance (result.squared_distance)
    );

endmodule

[hw/rtl/lmsd_wrap.sv]
// Coordinate wrap pipeline: per-coordinate remainder by the box side, then axis differences.
module lmsd_wrap
    import lmsd_pkg::*;
#(
    parameter int MAX_SIDE   = 256,
    parameter int COORD_BITS = 16,
    parameter int SIDE_W     = 9,
    parameter int DIFF_W     = 20
)(
    input  logic                     clk,
    input  logic                     rst_n,
    input  cfg_t                     cfg,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [FIELD_W-1:0]       coord [NUM_COORDS],
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic signed [DIFF_W-1:0] diff [NUM_AXES],
    output logic [SIDE_W-1:0]        side
);

    localparam int NDIV  = (COORD_BITS + DIV_STEP - 1) / DIV_STEP;
    localparam int NST   = NDIV + 2;
    localparam int CMP_W = (SIDE_W > SIDE_REG_W) ? SIDE_W : SIDE_REG_W;

    // effective side: zero reads as one, large values saturate
    logic [CMP_W-1:0]  side_raw;
    logic [SIDE_W-1:0] side_lim;
    logic              periodic;

    always_comb
    begin
        side_raw = CMP_W'(cfg.box_side);
        if (side_raw == '0)
        begin
            side_lim = SIDE_W'(1);
        end
        else if (side_raw > CMP_W'(MAX_SIDE))
        begin
            side_lim = SIDE_W'(MAX_SIDE);
        end
        else
        begin
            side_lim = SIDE_W'(side_raw);
        end
    end

    assign periodic = (cfg.mode == BOUND_PERIODIC);

    // stage handshake: a stage loads when it is empty or its successor moves
    logic [NST-1:0] vld_reg;
    logic [NST:0]   rdy;
    logic [NST-1:0] vld_in;

    assign rdy[NST]  = out_ready;
    assign vld_in    = {vld_reg[NST-2:0], in_valid};
    assign in_ready  = rdy[0];
    assign out_valid = vld_reg[NST-1];

    for (genvar k = 0; k < NST; k++)
    begin : g_rdy
        assign rdy[k] = !vld_reg[k] || rdy[k+1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            for (int k = 0; k < NST; k++)
            begin
                if (rdy[k])
                begin
                    vld_reg[k] <= vld_in[k];
                end
            end
        end
    end

    logic [COORD_BITS-1:0]        mag_reg [NDIV+1][NUM_COORDS];
    logic [NUM_COORDS-1:0]        neg_reg [NDIV+1];
    logic [SIDE_W-1:0]            rem_reg [NDIV+1][NUM_COORDS];
    logic signed [COORD_BITS:0]   sd_reg  [NDIV+1][NUM_AXES];

    // entry: read fields as COORD_BITS-bit numbers, split into sign and magnitude
    logic [COORD_BITS-1:0]      c_in   [NUM_COORDS];
    logic [COORD_BITS-1:0]      mag_in [NUM_COORDS];
    logic [NUM_COORDS-1:0]      neg_in;
    logic signed [COORD_BITS:0] sd_in  [NUM_AXES];

    always_comb
    begin
        for (int c = 0; c < NUM_COORDS; c++)
        begin
            c_in[c]   = COORD_BITS'(coord[c]);
            neg_in[c] = c_in[c][COORD_BITS-1];
            mag_in[c] = neg_in[c] ? (~c_in[c] + 1'b1) : c_in[c];
        end
        for (int a = 0; a < NUM_AXES; a++)
        begin
            sd_in[a] = {c_in[a][COORD_BITS-1], c_in[a]}
                     - {c_in[a+NUM_AXES][COORD_BITS-1], c_in[a+NUM_AXES]};
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy[0])
        begin
            for (int c = 0; c < NUM_COORDS; c++)
            begin
                mag_reg[0][c] <= mag_in[c];
                rem_reg[0][c] <= '0;
            end
            neg_reg[0] <= neg_in;
            for (int a = 0; a < NUM_AXES; a++)
            begin
                sd_reg[0][a] <= sd_in[a];
            end
        end
    end

    // restoring remainder, most significant bits first, DIV_STEP bits per stage
    for (genvar j = 1; j <= NDIV; j++)
    begin : g_div
        localparam int BASE = (j - 1) * DIV_STEP;

        logic [SIDE_W-1:0] rem_next [NUM_COORDS];

        always_comb
        begin
            logic [SIDE_W:0]   t;
            logic [SIDE_W-1:0] acc;
            for (int c = 0; c < NUM_COORDS; c++)
            begin
                acc = rem_reg[j-1][c];
                for (int q = 0; q < DIV_STEP; q++)
                begin
                    t = {acc, 1'b0};
                    if (BASE + q < COORD_BITS)
                    begin
                        t[0] = mag_reg[j-1][c][COORD_BITS-1-BASE-q];
                        if (t >= {1'b0, side_lim})
                        begin
                            t = t - {1'b0, side_lim};
                        end
                        acc = t[SIDE_W-1:0];
                    end
                end
                rem_next[c] = acc;
            end
        end

        always_ff @(posedge clk)
        begin
            if (rdy[j])
            begin
                for (int c = 0; c < NUM_COORDS; c++)
                begin
                    mag_reg[j][c] <= mag_reg[j-1][c];
                    rem_reg[j][c] <= rem_next[c];
                end
                neg_reg[j] <= neg_reg[j-1];
                for (int a = 0; a < NUM_AXES; a++)
                begin
                    sd_reg[j][a] <= sd_reg[j-1][a];
                end
            end
        end
    end

    // fold negative remainders into [0, L) and take axis differences
    logic [SIDE_W-1:0]          wrapped   [NUM_COORDS];
    logic signed [SIDE_W:0]     pd        [NUM_AXES];
    logic signed [DIFF_W-1:0]   diff_next [NUM_AXES];
    logic signed [DIFF_W-1:0]   diff_reg  [NUM_AXES];
    logic [SIDE_W-1:0]          side_next;
    logic [SIDE_W-1:0]          side_reg;

    always_comb
    begin
        for (int c = 0; c < NUM_COORDS; c++)
        begin
            if (neg_reg[NDIV][c] && (rem_reg[NDIV][c] != '0))
            begin
                wrapped[c] = side_lim - rem_reg[NDIV][c];
            end
            else
            begin
                wrapped[c] = rem_reg[NDIV][c];
            end
        end
        for (int a = 0; a < NUM_AXES; a++)
        begin
            pd[a] = {1'b0, wrapped[a]} - {1'b0, wrapped[a+NUM_AXES]};
            diff_next[a] = periodic ? DIFF_W'(pd[a]) : DIFF_W'(sd_reg[NDIV][a]);
        end
        // the static box passes a zero side, which collapses all images onto the plain difference
        side_next = periodic ? side_lim : '0;
    end

    always_ff @(posedge clk)
    begin
        if (rdy[NST-1])
        begin
            for (int a = 0; a < NUM_AXES; a++)
            begin
                diff_reg[a] <= diff_next[a];
            end
            side_reg <= side_next;
        end
    end

    assign diff = diff_reg;
    assign side = side_reg;

endmodule

[hw/rtl/lmsd_image_sq.sv]
// Image pipeline: per-axis image candidates, their squares, and the 27 squared norms.
module lmsd_image_sq
    import lmsd_pkg::*;
#(
    parameter int SIDE_W = 9,
    parameter int DIFF_W = 20
)(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic signed [DIFF_W-1:0] diff [NUM_AXES],
    input  logic [SIDE_W-1:0]        side,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic [2*DIFF_W-1:0]      norm [NIMG]
);

    localparam int NST   = 3;
    localparam int SQ_W  = 2 * DIFF_W - 2;
    localparam int SUM_W = 2 * DIFF_W;

    logic [NST-1:0] vld_reg;
    logic [NST:0]   rdy;
    logic [NST-1:0] vld_in;

    assign rdy[NST]  = out_ready;
    assign vld_in    = {vld_reg[NST-2:0], in_valid};
    assign in_ready  = rdy[0];
    assign out_valid = vld_reg[NST-1];

    for (genvar k = 0; k < NST; k++)
    begin : g_rdy
        assign rdy[k] = !vld_reg[k] || rdy[k+1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            for (int k = 0; k < NST; k++)
            begin
                if (rdy[k])
                begin
                    vld_reg[k] <= vld_in[k];
                end
            end
        end
    end

    // candidates: skewed transform of the difference plus whole-side offsets
    logic signed [DIFF_W-1:0] s1, s2, s3, xb, yb, zb;
    logic signed [DIFF_W-1:0] x_next [NX];
    logic signed [DIFF_W-1:0] y_next [NY];
    logic signed [DIFF_W-1:0] z_next [NZ];
    logic signed [DIFF_W-1:0] x_reg  [NX];
    logic signed [DIFF_W-1:0] y_reg  [NY];
    logic signed [DIFF_W-1:0] z_reg  [NZ];

    always_comb
    begin
        s1 = signed'(DIFF_W'(side));
        s2 = s1 <<< 1;
        s3 = s1 + s2;
        xb = diff[0] + diff[1] - diff[2];
        yb = diff[0] - diff[1];
        zb = diff[2];
        x_next[0] = xb - s3;
        x_next[1] = xb - s2;
        x_next[2] = xb - s1;
        x_next[3] = xb;
        x_next[4] = xb + s1;
        x_next[5] = xb + s2;
        x_next[6] = xb + s3;
        y_next[0] = yb - s2;
        y_next[1] = yb - s1;
        y_next[2] = yb;
        y_next[3] = yb + s1;
        y_next[4] = yb + s2;
        z_next[0] = zb - s1;
        z_next[1] = zb;
        z_next[2] = zb + s1;
    end

    always_ff @(posedge clk)
    begin
        if (rdy[0])
        begin
            x_reg <= x_next;
            y_reg <= y_next;
            z_reg <= z_next;
        end
    end

    // squares
    logic signed [2*DIFF_W-1:0] px [NX];
    logic signed [2*DIFF_W-1:0] py [NY];
    logic signed [2*DIFF_W-1:0] pz [NZ];
    logic [SQ_W-1:0] sqx_reg [NX];
    logic [SQ_W-1:0] sqy_reg [NY];
    logic [SQ_W-1:0] sqz_reg [NZ];

    always_comb
    begin
        for (int k = 0; k < NX; k++)
        begin
            px[k] = x_reg[k] * x_reg[k];
        end
        for (int k = 0; k < NY; k++)
        begin
            py[k] = y_reg[k] * y_reg[k];
        end
        for (int k = 0; k < NZ; k++)
        begin
            pz[k] = z_reg[k] * z_reg[k];
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy[1])
        begin
            for (int k = 0; k < NX; k++)
            begin
                sqx_reg[k] <= px[k][SQ_W-1:0];
            end
            for (int k = 0; k < NY; k++)
            begin
                sqy_reg[k] <= py[k][SQ_W-1:0];
            end
            for (int k = 0; k < NZ; k++)
            begin
                sqz_reg[k] <= pz[k][SQ_W-1:0];
            end
        end
    end

    // image (i, j, m): x shifts by i+j-m sides, y by i-j, z by m
    logic [SUM_W-1:0] sum_next [NIMG];
    logic [SUM_W-1:0] sum_reg  [NIMG];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                for (int m = 0; m < 3; m++)
                begin
                    sum_next[i*9 + j*3 + m] = SUM_W'(sqx_reg[i + j - m + 2])
                                            + SUM_W'(sqy_reg[i - j + 2])
                                            + SUM_W'(sqz_reg[m]);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy[2])
        begin
            sum_reg <= sum_next;
        end
    end

    assign norm = sum_reg;

endmodule

[hw/rtl/lmsd_min_tree.sv]
// Registered three-level minimum tree over the 27 image norms.
module lmsd_min_tree
    import lmsd_pkg::*;
#(
    parameter int SUM_W = 40
)(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [SUM_W-1:0] norm [NIMG],
    output logic             out_valid,
    input  logic             out_ready,
    output logic [OUT_W-1:0] squared_distance
);

    localparam int NST = 3;

    function automatic logic [SUM_W-1:0] min3(
        input logic [SUM_W-1:0] a,
        input logic [SUM_W-1:0] b,
        input logic [SUM_W-1:0] c
    );
        logic [SUM_W-1:0] m;
        m = (b < a) ? b : a;
        return (c < m) ? c : m;
    endfunction

    logic [NST-1:0] vld_reg;
    logic [NST:0]   rdy;
    logic [NST-1:0] vld_in;

    assign rdy[NST]  = out_ready;
    assign vld_in    = {vld_reg[NST-2:0], in_valid};
    assign in_ready  = rdy[0];
    assign out_valid = vld_reg[NST-1];

    for (genvar k = 0; k < NST; k++)
    begin : g_rdy
        assign rdy[k] = !vld_reg[k] || rdy[k+1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            for (int k = 0; k < NST; k++)
            begin
                if (rdy[k])
                begin
                    vld_reg[k] <= vld_in[k];
                end
            end
        end
    end

    logic [SUM_W-1:0] l1_reg [9];
    logic [SUM_W-1:0] l2_reg [3];
    logic [SUM_W-1:0] min_reg;

    always_ff @(posedge clk)
    begin
        if (rdy[0])
        begin
            for (int g = 0; g < 9; g++)
            begin
                l1_reg[g] <= min3(norm[3*g], norm[3*g + 1], norm[3*g + 2]);
            end
        end
        if (rdy[1])
        begin
            for (int g = 0; g < 3; g++)
            begin
                l2_reg[g] <= min3(l1_reg[3*g], l1_reg[3*g + 1], l1_reg[3*g + 2]);
            end
        end
        if (rdy[2])
        begin
            min_reg <= min3(l2_reg[0], l2_reg[1], l2_reg[2]);
        end
    end

    assign squared_distance = OUT_W'(min_reg);

endmodule

[hw/rtl/lmsd_checker.sv]
// Port-level checker for the lattice distance block and its bind to the top level.
module lmsd_checker
    import lmsd_pkg::*;
#(
    parameter int MAX_SIDE = 256
)(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  cfg_we,
    input logic [CFG_IDX_W-1:0]  cfg_index,
    input logic [CFG_DATA_W-1:0] cfg_data,
    input logic                  in_valid,
    input logic                  in_ready,
    input logic                  out_valid,
    input logic                  out_ready,
    input logic [OUT_W-1:0]      squared_distance
);

    // minimum-image bound: a periodic norm must stay below 4 L^2 with L = MAX_SIDE
    localparam longint PERIODIC_BOUND = 4 * longint'(MAX_SIDE) * longint'(MAX_SIDE);

    bound_mode_t mode_reg;
    logic [7:0]  cnt_reg;
    logic [7:0]  cnt_next;

    always_comb
    begin
        cnt_next = cnt_reg + {7'd0, in_valid && in_ready} - {7'd0, out_valid && out_ready};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= BOUND_PERIODIC;
            cnt_reg  <= '0;
        end
        else
        begin
            if (cfg_we && (cfg_index_t'(cfg_index) == CFG_BOUNDARY_MODE))
            begin
                mode_reg <= bound_mode_t'(cfg_data[0]);
            end
            cnt_reg <= cnt_next;
        end
    end

    a_reset_quiet: assert property (@(posedge clk) !rst_n |-> !out_valid)
        else $error("result valid during reset");

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(squared_distance))
        else $error("stalled result dropped or changed");

    a_no_orphan: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> cnt_reg != 8'd0)
        else $error("result without a pending pair");

    a_periodic_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (mode_reg == BOUND_PERIODIC)
        |-> 64'(squared_distance) < 64'(PERIODIC_BOUND))
        else $error("periodic distance exceeds minimum-image bound");

endmodule

bind lattice_min_image_sq_distance lmsd_checker #(
    .MAX_SIDE (MAX_SIDE)
) u_lmsd_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (pair.valid),
    .in_ready         (pair.ready),
    .out_valid        (result.valid),
    .out_ready        (result.ready),
    .squared_distance (result.squared_distance)
);

[tb/sv/lmsd_distance_checker.sv]
// Checker that predicts and compares squared lattice distances on the result stream.
module lmsd_distance_checker
    import lmsd_pkg::*;
#(
    parameter int MAX_SIDE = 256
)(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    lmsd_pair_if                  pair,
    lmsd_dist_if                  result,
    output int                    mismatches,
    output int                    outstanding
);

    bound_mode_t           mode_q;
    logic [SIDE_REG_W-1:0] side_q;
    logic [OUT_W-1:0]      exp_dist_q[$];
    logic [OUT_W-1:0]      want;
    int                    fail_cnt;

    function automatic longint lattice_norm(longint dt, longint du, longint dv);
        longint x;
        longint y;
        longint z;
        x = dt + du - dv;
        y = dt - du;
        z = dv;
        return x * x + y * y + z * z;
    endfunction

    // % truncates toward zero, so pull negative remainders back into the box
    function automatic longint box_wrap(longint c, longint side);
        longint r;
        r = c % side;
        if (r < 0)
            r = r + side;
        return r;
    endfunction

    function automatic logic [OUT_W-1:0] predict_sq_dist(
        bound_mode_t           mode,
        logic [SIDE_REG_W-1:0] side_reg,
        logic [FIELD_W-1:0]    at,
        logic [FIELD_W-1:0]    au,
        logic [FIELD_W-1:0]    av,
        logic [FIELD_W-1:0]    bt,
        logic [FIELD_W-1:0]    bu,
        logic [FIELD_W-1:0]    bv
    );
        longint pa[3];
        longint pb[3];
        longint d[3];
        longint side;
        longint best;
        longint cand;
        int     i;
        int     j;
        int     m;
        pa[0] = $signed(at);
        pa[1] = $signed(au);
        pa[2] = $signed(av);
        pb[0] = $signed(bt);
        pb[1] = $signed(bu);
        pb[2] = $signed(bv);
        if (mode == BOUND_STATIC) begin
            best = lattice_norm(pa[0] - pb[0], pa[1] - pb[1], pa[2] - pb[2]);
        end
        else begin
            side = longint'(side_reg);
            if (side < 1)
                side = 1;
            if (side > MAX_SIDE)
                side = MAX_SIDE;
            for (int k = 0; k < 3; k++)
                d[k] = box_wrap(pa[k], side) - box_wrap(pb[k], side);
            best = -1;
            for (i = -1; i <= 1; i++)
                for (j = -1; j <= 1; j++)
                    for (m = -1; m <= 1; m++) begin
                        cand = lattice_norm(d[0] + i * side, d[1] + j * side, d[2] + m * side);
                        if (best < 0 || cand < best)
                            best = cand;
                    end
        end
        return best[OUT_W-1:0];
    endfunction

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            mode_q <= BOUND_PERIODIC;
            side_q <= SIDE_RESET;
            exp_dist_q.delete();
            fail_cnt = 0;
            mismatches <= 0;
            outstanding <= 0;
        end
        else begin
            if (cfg_we) begin
                case (cfg_index_t'(cfg_index))
                    CFG_BOUNDARY_MODE: mode_q <= bound_mode_t'(cfg_data[0]);
                    CFG_BOX_SIDE:      side_q <= cfg_data[SIDE_REG_W-1:0];
                    default: ;
                endcase
            end
            if (pair.valid && pair.ready)
                exp_dist_q.push_back(predict_sq_dist(mode_q, side_q,
                    pair.point_a_t, pair.point_a_u, pair.point_a_v,
                    pair.point_b_t, pair.point_b_u, pair.point_b_v));
            if (result.valid && result.ready) begin
                if (exp_dist_q.size() == 0) begin
                    if (fail_cnt < 10)
                        $display("mismatch: unexpected squared_distance %0d",
                                 result.squared_distance);
                    fail_cnt++;
                end
                else begin
                    want = exp_dist_q.pop_front();
                    if (result.squared_distance !== want) begin
                        if (fail_cnt < 10)
                            $display("mismatch: squared_distance expected %0d actual %0d",
                                     want, result.squared_distance);
                        fail_cnt++;
                    end
                end
            end
            mismatches <= fail_cnt;
            outstanding <= exp_dist_q.size();
        end
    end

endmodule

[tb/sv/tb_lattice_min_image_sq_distance.sv]
// Stimulus and verdict for the lattice minimum-image squared distance block.
module tb_lattice_min_image_sq_distance;
    import lmsd_pkg::*;

    localparam int LAT_MAX_SIDE    = 256;
    localparam int LAT_COORD_BITS  = 16;
    localparam int PIPE_DRAIN      = 24;
    localparam int N_RAND_PHASES   = 17;
    localparam int ITEMS_PER_PHASE = 100;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    bit                    quiet;
    int                    mismatches;
    int                    outstanding;

    lmsd_pair_if pair();
    lmsd_dist_if result();

    lattice_min_image_sq_distance #(
        .MAX_SIDE   (LAT_MAX_SIDE),
        .COORD_BITS (LAT_COORD_BITS)
    ) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .pair      (pair),
        .result    (result)
    );

    lmsd_distance_checker #(
        .MAX_SIDE (LAT_MAX_SIDE)
    ) u_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .pair        (pair),
        .result      (result),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #1 clk = ~clk;

    // mostly short gaps, now and then a long one; none in quiet phases
    function automatic int idle_len();
        int r;
        if (quiet)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [FIELD_W-1:0] rand_coord(int s);
        int r;
        int k;
        r = $urandom_range(0, 9);
        k = int'($urandom_range(0, 6)) - 3;
        if (r <= 3)
            return FIELD_W'($urandom);
        if (r <= 6)
            return FIELD_W'(int'($urandom_range(0, 3 * s)) - s);
        if (r == 7) begin
            case ($urandom_range(0, 3))
                0:       return 16'h8000;
                1:       return 16'h7FFF;
                2:       return 16'h0000;
                default: return 16'hFFFF;
            endcase
        end
        // land on or next to a multiple of the side
        return FIELD_W'(k * s + int'($urandom_range(0, 2)) - 1);
    endfunction

    task automatic send_pair(input logic [FIELD_W-1:0] at, au, av, bt, bu, bv);
        bit took;
        int g;
        pair.valid     <= 1'b1;
        pair.point_a_t <= at;
        pair.point_a_u <= au;
        pair.point_a_v <= av;
        pair.point_b_t <= bt;
        pair.point_b_u <= bu;
        pair.point_b_v <= bv;
        do begin
            @(negedge clk);
            took = pair.ready;
            @(posedge clk);
        end while (!took);
        g = idle_len();
        if (g > 0) begin
            pair.valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
    endtask

    // drop valid, drain the pipeline, then write both registers
    task automatic reconfigure(input bound_mode_t mode, input logic [SIDE_REG_W-1:0] side);
        logic [CFG_DATA_W-1:0] junk;
        junk = CFG_DATA_W'($urandom);
        pair.valid <= 1'b0;
        do @(negedge clk); while (outstanding != 0);
        repeat (PIPE_DRAIN) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_BOUNDARY_MODE;
        cfg_data  <= {junk[CFG_DATA_W-1:1], mode};
        @(posedge clk);
        cfg_index <= CFG_BOX_SIDE;
        cfg_data  <= CFG_DATA_W'(side);
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    initial
    begin
        int g;
        result.ready <= 1'b0;
        do @(posedge clk); while (!rst_n);
        forever begin
            result.ready <= 1'b1;
            repeat ($urandom_range(1, 24)) @(posedge clk);
            g = idle_len();
            if (g > 0) begin
                result.ready <= 1'b0;
                repeat (g) @(posedge clk);
            end
        end
    end

    initial
    begin
        bound_mode_t           mode;
        logic [SIDE_REG_W-1:0] side;
        logic [FIELD_W-1:0]    a[3];
        logic [FIELD_W-1:0]    b[3];
        int                    s;
        rst_n          <= 1'b0;
        cfg_we         <= 1'b0;
        cfg_index      <= CFG_BOUNDARY_MODE;
        cfg_data       <= '0;
        pair.valid     <= 1'b0;
        pair.point_a_t <= '0;
        pair.point_a_u <= '0;
        pair.point_a_v <= '0;
        pair.point_b_t <= '0;
        pair.point_b_u <= '0;
        pair.point_b_v <= '0;
        quiet = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        repeat (4) @(posedge clk);

        // reset settings: periodic, side 64
        send_pair(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
        send_pair(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000, 16'h8000);
        send_pair(16'h8000, 16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h7FFF);
        send_pair(16'd63, 16'd63, 16'd63, 16'h0000, 16'h0000, 16'h0000);
        send_pair(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd64, 16'd64, 16'd64);

        // static box, including the largest possible distance
        reconfigure(BOUND_STATIC, 9'd64);
        send_pair(16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000, 16'h8000, 16'h7FFF);
        send_pair(16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h8000);
        send_pair(16'h1234, 16'hABCD, 16'h5555, 16'h1234, 16'hABCD, 16'h5555);
        send_pair(16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000);

        // zero side acts as one
        reconfigure(BOUND_PERIODIC, 9'd0);
        send_pair(16'h7FFF, 16'h8000, 16'h1234, 16'h8000, 16'h7FFF, 16'hFFFF);
        send_pair(16'h00FF, 16'hFF00, 16'h0F0F, 16'hF0F0, 16'h0001, 16'h8001);

        reconfigure(BOUND_PERIODIC, 9'd1);
        send_pair(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000, 16'h8000);
        send_pair(16'h0005, 16'hFFFB, 16'h0003, 16'h0000, 16'h0000, 16'h0000);

        reconfigure(BOUND_PERIODIC, 9'd256);
        send_pair(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000, 16'h8000);
        send_pair(16'd255, 16'h0000, 16'd128, 16'h0000, 16'd255, 16'd0);
        send_pair(16'hFF80, 16'd127, 16'h8000, 16'd128, 16'hFF81, 16'h7FFF);

        // sides above the maximum saturate
        reconfigure(BOUND_PERIODIC, 9'd511);
        send_pair(16'd255, 16'd1, 16'hFFFF, 16'h0000, 16'd200, 16'd128);
        send_pair(16'h7FFF, 16'h8000, 16'h7FFF, 16'h0000, 16'h0000, 16'h0000);

        reconfigure(BOUND_PERIODIC, 9'd257);
        send_pair(16'd256, 16'd129, 16'hFF00, 16'h0000, 16'h8000, 16'd127);

        // side has no effect on the static box
        reconfigure(BOUND_STATIC, 9'd0);
        send_pair(16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000, 16'h8000, 16'h7FFF);
        send_pair(16'd300, 16'hFED4, 16'd17, 16'h0000, 16'd5, 16'hFFF0);

        for (int ph = 0; ph < N_RAND_PHASES; ph++) begin
            mode = ($urandom_range(0, 3) == 0) ? BOUND_STATIC : BOUND_PERIODIC;
            if ($urandom_range(0, 9) < 3) begin
                case ($urandom_range(0, 6))
                    0:       side = 9'd0;
                    1:       side = 9'd1;
                    2:       side = 9'd2;
                    3:       side = 9'd255;
                    4:       side = 9'd256;
                    5:       side = 9'd257;
                    default: side = 9'd511;
                endcase
            end
            else begin
                side = SIDE_REG_W'($urandom_range(1, 256));
            end
            s = (side == 0) ? 1 : (side > LAT_MAX_SIDE) ? LAT_MAX_SIDE : int'(side);
            quiet = 1'b0;
            reconfigure(mode, side);
            quiet = ($urandom_range(0, 3) == 0);
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                for (int k = 0; k < 3; k++)
                    a[k] = rand_coord(s);
                if ($urandom_range(0, 2) == 0) begin
                    // nearby second point
                    for (int k = 0; k < 3; k++)
                        b[k] = FIELD_W'(int'($signed(a[k])) + int'($urandom_range(0, 2 * s)) - s);
                end
                else begin
                    for (int k = 0; k < 3; k++)
                        b[k] = rand_coord(s);
                end
                send_pair(a[0], a[1], a[2], b[0], b[1], b[2]);
            end
        end

        quiet = 1'b0;
        pair.valid <= 1'b0;
        do @(negedge clk); while (outstanding != 0);
        repeat (PIPE_DRAIN) @(posedge clk);
        if (mismatches == 0)
            $display("** lattice_min_image_sq_distance: PASSED **");
        else
            $display("** lattice_min_image_sq_distance: FAILED **");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("** lattice_min_image_sq_distance: FAILED **");
        $finish;
    end

endmodule
